// ===== hdl/tkhs_pkg.sv =====
// Shared types, sizes, operation codes and rank compare for the top-k hit selector.
package tkhs_pkg;

  // Store depth and counter width
  localparam int MAX_HITS = 64;
  localparam int CNT_W    = $clog2(MAX_HITS + 1);
  localparam int DOC_W    = 31;
  localparam int SCORE_W  = 32;

  // Operation codes carried in the input tuser
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // One stored hit
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [DOC_W-1:0]   doc;
  } hit_t;

  // Per-beat command broadcast to every cell
  typedef struct packed {
    logic grow;     // insert with room: open a slot at the sorted position
    logic replace;  // insert into a full store: drop cell 0, place new hit
    logic pop;      // remove cell 0, shift everything toward cell 0
  } cell_ctrl_t;

  // True when hit a ranks below hit b (lower score, or larger doc on a tie)
  function automatic logic ranks_below(input hit_t a, input hit_t b);
    logic res;
    if (a.score == b.score) begin
      res = (a.doc > b.doc);
    end else begin
      res = (a.score < b.score);
    end
    return res;
  endfunction

endpackage

// ===== hdl/top_k_hit_selector.sv =====
// Top level of the top-k hit selector: command decode, cell chain and result register.
//
// Keeps the best hits of a scored stream in a chain of 64 cells sorted by rank, the
// lowest-ranked hit always in cell 0. Every cell compares its hit with the incoming
// one in parallel and moves at most one slot, so any insert, pop or clear completes
// at once: one beat per clock sustained while the sink keeps up, with the result in
// an output register from the cycle after acceptance that lets the next beat in
// while it is taken. Input tuser carries the op (0 insert, 1 pop, 2 clear). Capacity
// (cfg_wdata, reset 64) is clamped to 64; zero drops every insert into an empty
// store, and a capacity below the current count makes the store act full without
// discarding anything. Write capacity only while the block is idle.
module top_k_hit_selector (
  input  logic        clk,
  input  logic        rst,
  // capacity register
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  // command beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [30:0] hit_doc, [62:31] hit_score, [63] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [30:0] out_doc, [62:31] out_score, [69:63] held
  output logic [1:0]  m_axis_tuser    // [0] out_valid, [1] kept
);

  localparam int N     = tkhs_pkg::MAX_HITS;
  localparam int CNT_W = tkhs_pkg::CNT_W;

  logic [CNT_W-1:0]     capacity;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W-1:0]     cap_eff;
  logic                 accept;
  logic [1:0]           op;
  tkhs_pkg::hit_t       new_hit;
  tkhs_pkg::cell_ctrl_t ctrl;
  tkhs_pkg::hit_t       cell_hit [N];
  logic [N-1:0]         cell_below;
  logic [N-1:0]         cell_valid;
  logic                 res_valid;
  logic                 res_kept;
  tkhs_pkg::hit_t       res_hit;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign op      = s_axis_tuser;
  assign new_hit = '{score: s_axis_tdata[62:31], doc: s_axis_tdata[30:0]};

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(N);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Clamp capacity to the store depth
  assign cap_eff = (capacity > CNT_W'(N)) ? CNT_W'(N) : capacity;

  // Decode the beat into a chain command
  always_comb begin
    ctrl = '0;
    if (accept) begin
      case (op)
        tkhs_pkg::OP_INSERT: begin
          if (count < cap_eff) begin
            ctrl.grow = 1'b1;
          end else begin
            ctrl.replace = cell_below[0];
          end
        end
        tkhs_pkg::OP_POP: begin
          ctrl.pop = (count != '0);
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  // Track the number of hits held
  always_comb begin
    count_next = count;
    if (ctrl.grow) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end else if (accept && op == tkhs_pkg::OP_CLEAR) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Build the chain of sorted cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    tkhs_pkg::hit_t left_hit;
    tkhs_pkg::hit_t right_hit;
    logic           left_below;
    logic           right_below;

    assign cell_valid[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_hit   = new_hit;
      assign left_below = 1'b1;
    end else begin : g_mid_left
      assign left_hit   = cell_hit[i-1];
      assign left_below = cell_below[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_hit   = cell_hit[i];
      assign right_below = 1'b0;
    end else begin : g_mid_right
      assign right_hit   = cell_hit[i+1];
      assign right_below = cell_below[i+1];
    end

    tkhs_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (cell_valid[i]),
      .new_hit     (new_hit),
      .left_hit    (left_hit),
      .left_below  (left_below),
      .right_hit   (right_hit),
      .right_below (right_below),
      .hit         (cell_hit[i]),
      .below       (cell_below[i])
    );
  end

  // Form the result fields of this beat
  assign res_valid = ctrl.pop;
  assign res_kept  = ctrl.grow || ctrl.replace;
  assign res_hit   = ctrl.pop ? cell_hit[0] : '0;

  // Hold the result until the sink takes it
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {2'b00, count_next, res_hit.score, res_hit.doc};
      m_axis_tuser <= {res_kept, res_valid};
    end
  end

  // The count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(N))
    else $error("hit count above store depth");

  // A beat never both returns a hit and keeps one
  a_pop_or_keep: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result both popped and kept");

  // A pending result reports the live count
  a_held_matches: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[69:63] == count))
    else $error("reported held differs from count");

  // The two lowest cells stay in rank order
  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> !tkhs_pkg::ranks_below(cell_hit[1], cell_hit[0]))
    else $error("cell chain out of rank order");

endmodule

// ===== hdl/tkhs_cell.sv =====
// One slot of the sorted hit chain; cell 0 holds the lowest-ranked hit.
module tkhs_cell (
  input  logic                clk,
  input  tkhs_pkg::cell_ctrl_t ctrl,
  input  logic                valid,       // this slot lies below the hit count
  input  tkhs_pkg::hit_t      new_hit,
  input  tkhs_pkg::hit_t      left_hit,
  input  logic                left_below,
  input  tkhs_pkg::hit_t      right_hit,
  input  logic                right_below,
  output tkhs_pkg::hit_t      hit,
  output logic                below
);

  tkhs_pkg::hit_t hit_next;

  // Flag a held hit that ranks below the incoming one
  always_comb begin
    below = valid && tkhs_pkg::ranks_below(hit, new_hit);
  end

  // Pick the slot's next content from self, neighbors or the new hit
  always_comb begin
    hit_next = hit;
    if (ctrl.grow) begin
      if (below) begin
        hit_next = hit;
      end else if (left_below) begin
        hit_next = new_hit;
      end else begin
        hit_next = left_hit;
      end
    end else if (ctrl.replace) begin
      if (right_below) begin
        hit_next = right_hit;
      end else if (below) begin
        hit_next = new_hit;
      end else begin
        hit_next = hit;
      end
    end else if (ctrl.pop) begin
      hit_next = right_hit;
    end
  end

  // Advance the slot on any store-changing beat
  always_ff @(posedge clk) begin
    if (ctrl.grow || ctrl.replace || ctrl.pop) begin
      hit <= hit_next;
    end
  end

endmodule
